/* rtl/bitmap_vram_port_with_write_protect_macros.svh */
`ifndef BITMAP_VRAM_PORT_WITH_WRITE_PROTECT_MACROS_SVH
`define BITMAP_VRAM_PORT_WITH_WRITE_PROTECT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BVRAM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bitmap vram port: same-cycle check failed");

// next-cycle implication, checked outside reset
`define BVRAM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bitmap vram port: next-cycle check failed");

`endif

/* rtl/bvram_pkg.sv */
package bvram_pkg;

   localparam int PLANE_AW    = 14;
   localparam int PLANE_DEPTH = 1 << PLANE_AW;
   localparam int WP_AW       = 8;
   localparam int WP_DEPTH    = 1 << WP_AW;

   localparam logic [15:0] PIXEL_ADDR   = 16'h0002;
   localparam logic [15:0] X_ADDR       = 16'h0000;
   localparam logic [15:0] Y_ADDR       = 16'h0001;
   localparam logic [15:0] DIRECT_LIMIT = 16'h4fff;
   localparam logic [15:0] LATCH_MASK   = 16'hff80;
   localparam logic [15:0] LATCH_BASE   = 16'h5580;
   localparam logic [3:0]  PLANE1_PAGE  = 4'h4;
   localparam logic [3:0]  PIXEL_FILL   = 4'hf;

   localparam int LATCH_HOLD_X = 0;
   localparam int LATCH_HOLD_Y = 1;
   localparam int LATCH_WP_A   = 4;
   localparam int LATCH_WP_B   = 6;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_LOAD  = 2'd2
   } kind_type;

endpackage

/* rtl/bitmap_vram_port_with_write_protect.sv */
// Bitmap video memory port with nibble write protection. On acceptance of an
// item, both 16K x 8 planes and the 256 x 4 write-protect table are read into
// registers (synchronous read); then, once the result side is free, the block
// merges nibbles, writes both planes back for a plane write and loads the result
// register. The block takes a new item while a finished result waits in that
// register, but that item's merge and write-back wait until the result is taken.
// After reset the planes are cleared by a pass over every offset, one offset of
// both planes per cycle, during which req_ready stays low. The write-protect
// table is not cleared and must be loaded before any write that reads it.
`include "bitmap_vram_port_with_write_protect_macros.svh"

module bitmap_vram_port_with_write_protect (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data
);
   import bvram_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type             state_ff;
   logic [PLANE_AW-1:0]   clr_ff;
   logic [1:0]            kind_ff;
   logic [15:0]           addr_ff;
   logic [7:0]            data_ff;
   logic [PLANE_AW-1:0]   off_ff;
   logic                  pix_ff;
   logic [7:0]            pixel_x_ff, pixel_x_in;
   logic [7:0]            pixel_y_ff, pixel_y_in;
   logic [7:0]            latch_ff;
   logic                  rsp_valid_ff;
   logic [7:0]            rsp_data_ff, rsp_data_in;

   logic [7:0]            plane0_mem [PLANE_DEPTH];
   logic [7:0]            plane1_mem [PLANE_DEPTH];
   logic [3:0]            wp_mem [WP_DEPTH];
   logic [7:0]            p0_rd_ff, p1_rd_ff;
   logic [3:0]            wp_rd_ff;

   logic                  req_fire, exec_go, is_pixel;
   logic [PLANE_AW-1:0]   pix_off, rd_off, wr_off;
   logic [WP_AW-1:0]      wp_idx;
   logic                  is_direct, is_latch, is_write, is_read;
   logic                  mem_we, plane_we, step;
   logic [7:0]            wr_byte, new0, new1, wdata0, wdata1, pix_byte;
   logic [3:0]            pix_nib;

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_fire      = req_valid && req_ready;
   assign exec_go       = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // address and table index for the read at acceptance
   always_comb begin
      is_pixel = (req_address == PIXEL_ADDR);
      pix_off  = {pixel_y_ff, pixel_x_ff[7:2]};
      rd_off   = is_pixel ? pix_off : req_address[PLANE_AW-1:0];
      if (is_pixel) begin
         wp_idx = {1'b1, latch_ff[LATCH_WP_A], latch_ff[LATCH_WP_B], 1'b1,
                   pix_off[13:11] == 3'b000, pix_off[10:9] == 2'b11,
                   pixel_x_ff[1:0]};
      end else begin
         wp_idx = {1'b0, latch_ff[LATCH_WP_A], latch_ff[LATCH_WP_B],
                   req_address[15:12] != PLANE1_PAGE,
                   req_address[13:11] == 3'b000, req_address[10:9] == 2'b11,
                   2'b00};
      end
   end

   // merge and write back in the execute state
   always_comb begin
      is_write  = (kind_ff == KIND_WRITE);
      is_read   = (kind_ff == KIND_READ);
      is_direct = (addr_ff <= DIRECT_LIMIT);
      is_latch  = ((addr_ff & LATCH_MASK) == LATCH_BASE);
      wr_byte   = pix_ff ? {data_ff[3:0], data_ff[3:0]} : data_ff;
      new1 = {wp_rd_ff[0] ? p1_rd_ff[7:4] : wr_byte[7:4],
              wp_rd_ff[1] ? p1_rd_ff[3:0] : wr_byte[3:0]};
      new0 = {wp_rd_ff[2] ? p0_rd_ff[7:4] : wr_byte[7:4],
              wp_rd_ff[3] ? p0_rd_ff[3:0] : wr_byte[3:0]};
      mem_we   = exec_go && is_write && (pix_ff || is_direct);
      plane_we = (state_ff == ST_CLEAR) || mem_we;
      wr_off   = (state_ff == ST_CLEAR) ? clr_ff : off_ff;
      wdata0   = (state_ff == ST_CLEAR) ? 8'h00 : new0;
      wdata1   = (state_ff == ST_CLEAR) ? 8'h00 : new1;
      pix_byte = pixel_x_ff[1] ? p0_rd_ff : p1_rd_ff;
      pix_nib  = pixel_x_ff[0] ? pix_byte[3:0] : pix_byte[7:4];

      rsp_data_in = 8'h00;
      if (is_read) begin
         if (pix_ff) begin
            rsp_data_in = {PIXEL_FILL, pix_nib};
         end else if (is_direct) begin
            rsp_data_in = addr_ff[PLANE_AW] ? p1_rd_ff : p0_rd_ff;
         end
      end

      step       = exec_go && pix_ff && (is_read || is_write);
      pixel_x_in = pixel_x_ff;
      pixel_y_in = pixel_y_ff;
      if (step) begin
         if (!latch_ff[LATCH_HOLD_X]) begin
            pixel_x_in = pixel_x_ff + 8'd1;
         end
         if (!latch_ff[LATCH_HOLD_Y]) begin
            pixel_y_in = pixel_y_ff + 8'd1;
         end
      end else if (exec_go && is_write) begin
         if (addr_ff == X_ADDR) begin
            pixel_x_in = data_ff;
         end else if (addr_ff == Y_ADDR) begin
            pixel_y_in = data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pixel_x_ff   <= '0;
         pixel_y_ff   <= '0;
         latch_ff     <= '0;
      end else begin
         pixel_x_ff <= pixel_x_in;
         pixel_y_ff <= pixel_y_in;
         if (exec_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == {PLANE_AW{1'b1}}) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (exec_go) begin
                  state_ff <= ST_IDLE;
                  if (is_write && is_latch) begin
                     latch_ff[addr_ff[2:0]] <= data_ff[7];
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= req_kind;
         addr_ff <= req_address;
         data_ff <= req_write_data;
         off_ff  <= rd_off;
         pix_ff  <= is_pixel;
      end
      if (exec_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (plane_we) begin
         plane0_mem[wr_off] <= wdata0;
         plane1_mem[wr_off] <= wdata1;
      end
      if (req_fire) begin
         p0_rd_ff <= plane0_mem[rd_off];
         p1_rd_ff <= plane1_mem[rd_off];
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go && (kind_ff == KIND_LOAD)) begin
         wp_mem[addr_ff[WP_AW-1:0]] <= data_ff[3:0];
      end
      if (req_fire) begin
         wp_rd_ff <= wp_mem[wp_idx];
      end
   end

   `BVRAM_ASSERT_NOW(a_no_accept_in_clear, state_ff == ST_CLEAR, !req_ready)
   `BVRAM_ASSERT_NOW(a_no_write_while_idle, state_ff == ST_IDLE, !mem_we)
   `BVRAM_ASSERT_NEXT(a_exec_gives_result, exec_go, rsp_valid_ff && state_ff == ST_IDLE)
   `BVRAM_ASSERT_NEXT(a_write_reads_zero, exec_go && !is_read, rsp_data_ff == 8'h00)
   `BVRAM_ASSERT_NEXT(a_pixel_x_steps, step && !latch_ff[LATCH_HOLD_X],
                      pixel_x_ff == $past(pixel_x_ff) + 8'd1)

endmodule

/* tb/vram_access_checker.sv */
module vram_access_checker
   import bvram_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_read_data,
   output int          mismatches,
   output int          awaiting,
   output int          results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [15:0] LOW_BAND_MASK  = 16'h3800;
   localparam logic [15:0] HIGH_BAND_MASK = 16'h0600;
   localparam int          REPORT_LIMIT   = 10;

   logic [7:0] plane_bytes [0:2*PLANE_DEPTH-1];
   logic [3:0] guard_table [0:WP_DEPTH-1];
   logic [7:0] cursor_x;
   logic [7:0] cursor_y;
   logic [7:0] latches;
   logic [7:0] read_data_due [$];

   function automatic void merge_nibbles(input logic [15:0] a, input logic [7:0] d,
                                         input logic pixmode, input logic [1:0] lane);
      logic [7:0]  slot;
      logic [3:0]  guard;
      logic [13:0] off;
      logic [7:0]  p0;
      logic [7:0]  p1;
      off  = a[13:0];
      slot = {pixmode, latches[LATCH_WP_A], latches[LATCH_WP_B],
              a[15:12] != PLANE1_PAGE,
              (a & LOW_BAND_MASK) == 16'h0000,
              (a & HIGH_BAND_MASK) == HIGH_BAND_MASK,
              lane};
      guard = guard_table[slot];
      p0 = plane_bytes[{1'b0, off}];
      p1 = plane_bytes[{1'b1, off}];
      if (!guard[0]) p1[7:4] = d[7:4];
      if (!guard[1]) p1[3:0] = d[3:0];
      if (!guard[2]) p0[7:4] = d[7:4];
      if (!guard[3]) p0[3:0] = d[3:0];
      plane_bytes[{1'b0, off}] = p0;
      plane_bytes[{1'b1, off}] = p1;
   endfunction

   function automatic void step_cursor();
      if (!latches[LATCH_HOLD_X]) cursor_x = cursor_x + 8'd1;
      if (!latches[LATCH_HOLD_Y]) cursor_y = cursor_y + 8'd1;
   endfunction

   function automatic logic [7:0] predict_read_data(input logic [1:0] k, input logic [15:0] a,
                                                    input logic [7:0] d);
      logic [7:0] value;
      logic [7:0] b;
      value = 8'h00;
      case (k)
         KIND_READ: begin
            if (a == PIXEL_ADDR) begin
               b = plane_bytes[{~cursor_x[1], cursor_y, cursor_x[7:2]}];
               value = {PIXEL_FILL, cursor_x[0] ? b[3:0] : b[7:4]};
               step_cursor();
            end else if (a <= DIRECT_LIMIT) begin
               value = plane_bytes[a[14:0]];
            end
         end
         KIND_WRITE: begin
            if (a == PIXEL_ADDR) begin
               merge_nibbles({2'b00, cursor_y, cursor_x[7:2]}, {2{d[3:0]}}, 1'b1,
                             cursor_x[1:0]);
               step_cursor();
            end else if (a <= DIRECT_LIMIT) begin
               merge_nibbles(a, d, 1'b0, 2'b00);
               if (a == X_ADDR) cursor_x = d;
               else if (a == Y_ADDR) cursor_y = d;
            end else if ((a & LATCH_MASK) == LATCH_BASE) begin
               latches[a[2:0]] = d[7];
            end
         end
         KIND_LOAD: begin
            guard_table[a[7:0]] = d[3:0];
         end
         default: ;
      endcase
      return value;
   endfunction

   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         for (int i = 0; i < 2*PLANE_DEPTH; i++) plane_bytes[i] = 8'h00;
         for (int i = 0; i < WP_DEPTH; i++) guard_table[i] = 4'h0;
         cursor_x = 8'h00;
         cursor_y = 8'h00;
         latches  = 8'h00;
         read_data_due.delete();
         mismatches   = 0;
         results_seen = 0;
      end else begin
         if (req_valid && req_ready)
            read_data_due.push_back(predict_read_data(req_kind, req_address, req_write_data));
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (read_data_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected item: read_data %02h with nothing pending", rsp_read_data);
            end else begin
               want = read_data_due.pop_front();
               if (rsp_read_data !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("read_data mismatch: expected %02h, got %02h", want, rsp_read_data);
               end
            end
         end
      end
      awaiting = read_data_due.size();
   end

endmodule

/* tb/bitmap_vram_port_with_write_protect_tb.sv */
module bitmap_vram_port_with_write_protect_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bvram_pkg::*;

   localparam logic [1:0] KIND_SPARE      = 2'd3;
   localparam int         WATCHDOG_LIMIT  = 50000;
   localparam int         DRAIN_CYCLES    = 8;
   localparam int         HOLD_OFF_CYCLES = 400;
   localparam int         RANDOM_ITEMS    = 1200;
   localparam int         BURST_ITEMS     = 24;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_kind = KIND_READ;
   logic [15:0] req_address = 16'h0000;
   logic [7:0]  req_write_data = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;

   int mismatches;
   int awaiting;
   int results_seen;
   int items_sent = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int idle_plan [4] = '{0, 76, 0, 37};
   int stall_plan [4] = '{0, 0, 76, 37};

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   bitmap_vram_port_with_write_protect dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data)
   );

   vram_access_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .mismatches     (mismatches),
      .awaiting       (awaiting),
      .results_seen   (results_seen)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_OFF_CYCLES;
         rsp_ready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [1:0] kind, input logic [15:0] addr,
                            input logic [7:0] data);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_address    <= addr;
      req_write_data <= data;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      items_sent++;
   endtask

   task automatic random_traffic(input int target);
      int pick;
      int run;
      logic [15:0] spot;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            send_item(KIND_WRITE, X_ADDR, 8'($urandom));
            send_item(KIND_WRITE, Y_ADDR, 8'($urandom));
            run = $urandom_range(1, 8);
            repeat (run)
               send_item($urandom_range(1) ? KIND_WRITE : KIND_READ, PIXEL_ADDR, 8'($urandom));
         end else if (pick < 60) begin
            spot = 16'($urandom_range(0, DIRECT_LIMIT));
            send_item(KIND_WRITE, spot, 8'($urandom));
            if ($urandom_range(1)) send_item(KIND_READ, spot, 8'($urandom));
            send_item(KIND_READ, 16'($urandom_range(0, DIRECT_LIMIT)), 8'($urandom));
         end else if (pick < 72) begin
            send_item(KIND_WRITE, LATCH_BASE + 16'($urandom_range(0, 127)), 8'($urandom));
         end else if (pick < 80) begin
            send_item(KIND_LOAD, 16'($urandom), 8'($urandom));
         end else begin
            send_item(2'($urandom), 16'($urandom), 8'($urandom));
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < WP_DEPTH; i++)
         send_item(KIND_LOAD, {8'($urandom), 8'(i)},
                   {4'($urandom), ($urandom_range(3) == 0) ? 4'h0 : 4'($urandom)});

      send_item(KIND_READ, X_ADDR, 8'h00);
      send_item(KIND_WRITE, X_ADDR, 8'hff);
      send_item(KIND_WRITE, Y_ADDR, 8'hff);
      send_item(KIND_WRITE, PIXEL_ADDR, 8'h0f);
      send_item(KIND_READ, PIXEL_ADDR, 8'h00);
      send_item(KIND_WRITE, X_ADDR, 8'hff);
      send_item(KIND_WRITE, Y_ADDR, 8'hff);
      send_item(KIND_READ, PIXEL_ADDR, 8'h00);
      send_item(KIND_WRITE, 16'h4000, 8'ha5);
      send_item(KIND_READ, 16'h4000, 8'h00);
      send_item(KIND_READ, DIRECT_LIMIT, 8'h00);
      send_item(KIND_WRITE, 16'h3fff, 8'h5a);
      send_item(KIND_READ, 16'h3fff, 8'h00);
      send_item(KIND_READ, 16'h5000, 8'h00);
      send_item(KIND_WRITE, 16'hffff, 8'hff);
      send_item(KIND_READ, 16'hffff, 8'hff);
      send_item(KIND_SPARE, 16'hffff, 8'hff);
      send_item(KIND_WRITE, LATCH_BASE + 16'(LATCH_HOLD_X), 8'h80);
      send_item(KIND_WRITE, LATCH_BASE + 16'(LATCH_HOLD_Y), 8'h80);
      send_item(KIND_WRITE, LATCH_BASE + 16'(LATCH_WP_A), 8'hff);
      send_item(KIND_WRITE, LATCH_BASE + 16'(LATCH_WP_B), 8'hff);
      send_item(KIND_WRITE, PIXEL_ADDR, 8'h03);
      send_item(KIND_READ, PIXEL_ADDR, 8'h00);
      send_item(KIND_WRITE, 16'h0600, 8'h3c);
      send_item(KIND_WRITE, 16'h55ff, 8'h00);
      send_item(KIND_WRITE, 16'h5600, 8'h80);
      send_item(KIND_WRITE, LATCH_BASE + 16'(LATCH_HOLD_X), 8'h00);
      send_item(KIND_WRITE, LATCH_BASE + 16'(LATCH_HOLD_Y), 8'h00);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_plan[ph];
         rsp_stall_pct = stall_plan[ph];
         random_traffic(items_sent + RANDOM_ITEMS / 4);
         if (ph == 0) begin
            hold_requests++;
            random_traffic(items_sent + BURST_ITEMS);
         end
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (awaiting != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d items (table loads, directed corners, four idle/stall mixes,", items_sent);
      $display("one long result hold-off); %0d results compared", results_seen);
      if (mismatches == 0 && awaiting == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/bvram_pkg.sv
rtl/bitmap_vram_port_with_write_protect.sv
tb/vram_access_checker.sv
tb/bitmap_vram_port_with_write_protect_tb.sv
